[src/rpd_pkg.sv]
// Shared types and constants for the reply packet deframer.
// Used by rpd_crc16x25, rpd_parser and reply_packet_deframer_crc16_core.
`timescale 1ns / 1ps

package rpd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;  // reflected 0x1021

  localparam logic [7:0] CAPACITY_RESET = 8'd32;

  // header type codes, top two bits of the header byte
  localparam logic [1:0] TYPE_COMMAND = 2'd0;
  localparam logic [1:0] TYPE_REPLY   = 2'd1;
  localparam logic [1:0] TYPE_REPORT  = 2'd2;
  localparam logic [1:0] TYPE_ERROR   = 2'd3;

  // closing status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CRC_BAD   = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_DEV_ERROR = 3'd3;
  localparam logic [2:0] ST_CMD_TYPE  = 3'd4;
  localparam logic [2:0] ST_RPT_TYPE  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC_LO  = 6'b001000,
    PH_CRC_HI  = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic [4:0]  data_index;
    logic [5:0]  reply_command;
    logic [7:0]  reply_length;
    logic [2:0]  status;
    logic [15:0] crc_computed;
    logic [15:0] crc_received;
  } result_t;

endpackage

[src/rpd_crc16x25.sv]
// Byte-wide CRC-16/X-25 update, reflected, LSB first.
// Depends on rpd_pkg for the polynomial.
`timescale 1ns / 1ps

module rpd_crc16x25 import rpd_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[src/rpd_parser.sv]
// Packet parser: phase register, running CRC and header fields.
// Depends on rpd_pkg and rpd_crc16x25. One word per enabled cycle.
`timescale 1ns / 1ps

module rpd_parser import rpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  logic          chunk_end,
  input  logic [7:0]    capacity,
  output logic          res_valid,
  output result_t       res
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  phase_t            phase, phase_next;
  logic [15:0]       crc, crc_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [7:0]        length_reg, length_reg_next;
  logic [5:0]        command_reg, command_reg_next;
  logic [7:0]        crc_low_reg, crc_low_reg_next;

  logic [15:0]       crc_seed, crc_fed;
  logic [CNT_W-1:0]  cnt_inc;
  logic [7:0]        cnt_ext;

  assign crc_seed = (phase == PH_HEADER) ? CRC_INIT : crc;
  assign cnt_inc  = byte_count + 1'b1;
  assign cnt_ext  = 8'(byte_count);

  rpd_crc16x25 u_crc (
    .crc_in (crc_seed),
    .data   (rx_byte),
    .crc_out(crc_fed)
  );

  always_comb begin
    logic       emit;
    logic [2:0] st;
    logic [15:0] comp;
    logic [15:0] recv;
    phase_next       = phase;
    crc_next         = crc;
    byte_count_next  = byte_count;
    length_reg_next  = length_reg;
    command_reg_next = command_reg;
    crc_low_reg_next = crc_low_reg;
    emit             = 1'b0;
    st               = ST_OK;
    comp             = 16'h0000;
    recv             = 16'h0000;
    res_valid        = 1'b0;
    res              = '0;

    case (phase)
      PH_HEADER: begin
        command_reg_next = rx_byte[5:0];
        length_reg_next  = 8'h00;
        byte_count_next  = '0;
        crc_next         = crc_fed;
        case (rx_byte[7:6])
          TYPE_COMMAND: begin
            emit = 1'b1;
            st   = ST_CMD_TYPE;
          end
          TYPE_REPORT: begin
            emit = 1'b1;
            st   = ST_RPT_TYPE;
          end
          TYPE_ERROR: begin
            emit = 1'b1;
            st   = ST_DEV_ERROR;
          end
          default: begin
            if (chunk_end) begin
              emit = 1'b1;
              st   = ST_TRUNCATED;
            end else begin
              phase_next = PH_LENGTH;
            end
          end
        endcase
      end
      PH_LENGTH: begin
        length_reg_next = rx_byte;
        crc_next        = crc_fed;
        if (rx_byte > MAX_LEN || rx_byte > capacity) begin
          emit = 1'b1;
          st   = ST_TOO_LONG;
        end else if (chunk_end) begin
          emit = 1'b1;
          st   = ST_TRUNCATED;
        end else begin
          byte_count_next = '0;
          phase_next      = (rx_byte == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (chunk_end) begin
          emit = 1'b1;
          st   = ST_TRUNCATED;
        end else begin
          crc_next            = crc_fed;
          res_valid           = 1'b1;
          res.out_kind        = KIND_PAYLOAD;
          res.data_byte       = rx_byte;
          res.data_index      = cnt_ext[4:0];
          res.reply_command   = command_reg;
          res.reply_length    = length_reg;
          byte_count_next     = cnt_inc;
          if (8'(cnt_inc) >= length_reg) begin
            phase_next = PH_CRC_LO;
          end
        end
      end
      PH_CRC_LO: begin
        crc_low_reg_next = rx_byte;
        if (chunk_end) begin
          emit = 1'b1;
          st   = ST_TRUNCATED;
        end else begin
          phase_next = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        recv = {rx_byte, crc_low_reg};
        comp = ~crc;
        emit = 1'b1;
        st   = (comp == recv) ? ST_OK : ST_CRC_BAD;
      end
      default: begin
        if (chunk_end) begin
          phase_next = PH_HEADER;
        end
      end
    endcase

    // status closes the packet; header and length come from this word's update
    if (emit) begin
      res_valid         = 1'b1;
      res.out_kind      = KIND_STATUS;
      res.reply_command = command_reg_next;
      res.reply_length  = length_reg_next;
      res.status        = st;
      res.crc_computed  = comp;
      res.crc_received  = recv;
      phase_next        = chunk_end ? PH_HEADER : PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      crc         <= CRC_INIT;
      byte_count  <= '0;
      length_reg  <= 8'h00;
      command_reg <= 6'h00;
      crc_low_reg <= 8'h00;
    end else if (step) begin
      phase       <= phase_next;
      crc         <= crc_next;
      byte_count  <= byte_count_next;
      length_reg  <= length_reg_next;
      command_reg <= command_reg_next;
      crc_low_reg <= crc_low_reg_next;
    end
  end

endmodule

[src/reply_packet_deframer_crc16_core.sv]
// Top level of the reply packet deframer with CRC-16/X-25 check.
// Depends on rpd_pkg and rpd_parser.
`timescale 1ns / 1ps

// Takes one received byte per word, with tlast on the last byte of a chunk, and
// parses header (type, command), length, payload and a little-endian X-25 CRC.
// Payload bytes of reply packets come out as they arrive (tuser 0); every
// packet closes with one status word (tuser 1). After a status the rest of the
// chunk is dropped. A word is taken every cycle as long as the output side
// keeps up: it passes an input register, is parsed combinationally by the
// phase logic and byte-wide CRC, and lands in an output register.
// reply_capacity is written on the cfg channel (reset 32); the user must write
// it only while no packet is in flight, as the block does not enforce this.

module reply_packet_deframer_crc16_core import rpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // chunk_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [12:8] data_index, [18:13] reply_command,
  // [26:19] reply_length, [29:27] status, [45:30] crc_computed,
  // [61:46] crc_received, [63:62] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] out_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // reply_capacity
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic [7:0] capacity;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  rpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .chunk_end(in_last),
    .capacity (capacity),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.out_kind;
  assign m_axis_tdata = {2'b00,
                         out_res.crc_received,
                         out_res.crc_computed,
                         out_res.status,
                         out_res.reply_length,
                         out_res.reply_command,
                         out_res.data_index,
                         out_res.data_byte};

endmodule
